// ----- rtl/bts_pkg.sv -----
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types, token codes and keyword table for the basic token scanner.
// ----------------------------------------------------------------------------
package bts_pkg;

   localparam int STRING_CAP_DEF = 64;
   localparam int NAME_CAP_DEF   = 9;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

   localparam logic [30:0] VAL_MAX   = 31'h7FFF_FFFF;
   localparam logic [30:0] FRAC_LIM  = 31'd214748363;
   localparam logic [15:0] LINE_MAX  = 16'hFFFF;

   localparam logic [5:0] K_EOF   = 6'd0;
   localparam logic [5:0] K_EOL   = 6'd1;
   localparam logic [5:0] K_STR   = 6'd2;
   localparam logic [5:0] K_INT   = 6'd3;
   localparam logic [5:0] K_REAL  = 6'd4;
   localparam logic [5:0] K_IDENT = 6'd5;
   localparam logic [5:0] K_KW0   = 6'd6;
   localparam logic [5:0] K_EQ    = 6'd23;
   localparam logic [5:0] K_PLUS  = 6'd24;
   localparam logic [5:0] K_MINUS = 6'd25;
   localparam logic [5:0] K_MUL   = 6'd26;
   localparam logic [5:0] K_DIV   = 6'd27;
   localparam logic [5:0] K_LPAR  = 6'd28;
   localparam logic [5:0] K_RPAR  = 6'd29;
   localparam logic [5:0] K_COMMA = 6'd30;
   localparam logic [5:0] K_SEMI  = 6'd31;
   localparam logic [5:0] K_COLON = 6'd32;
   localparam logic [5:0] K_LTE   = 6'd33;
   localparam logic [5:0] K_NEQ   = 6'd34;
   localparam logic [5:0] K_LT    = 6'd35;
   localparam logic [5:0] K_GTE   = 6'd36;
   localparam logic [5:0] K_GT    = 6'd37;
   localparam logic [5:0] K_ERR   = 6'd38;

   localparam logic [2:0] E_NONE     = 3'd0;
   localparam logic [2:0] E_UNTERM   = 3'd1;
   localparam logic [2:0] E_STR_LONG = 3'd2;
   localparam logic [2:0] E_NAME_LONG = 3'd3;
   localparam logic [2:0] E_BAD_CHAR = 3'd4;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;

   // keyword names packed first byte lowest
   localparam logic [63:0] KW_NAME [17] = '{
      64'h0000_0000_0054_454C, 64'h0000_0054_4E49_5250,
      64'h0000_0054_5550_4E49, 64'h0000_0000_0000_4649,
      64'h0000_0000_4E45_4854, 64'h0000_0000_4553_4C45,
      64'h0000_0000_4F54_4F47, 64'h0000_0042_5553_4F47,
      64'h0000_4E52_5554_4552, 64'h0000_0000_0052_4F46,
      64'h0000_0000_0000_4F54, 64'h0000_0000_5045_5453,
      64'h0000_0000_5458_454E, 64'h0000_0000_0044_4E45,
      64'h0000_0000_0044_4E41, 64'h0000_0000_0000_524F,
      64'h0000_0000_0054_4F4E
   };

   localparam logic [23:0] REM_NAME = 24'h4D_45_52;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] line;
      logic [30:0] value;
      logic [5:0]  frac;
      logic [63:0] name;
      logic [3:0]  len;
      logic [2:0]  err;
      logic        drain;
      logic [5:0]  count;
   } cmd_type;

   typedef struct packed {
      logic       found;
      logic [5:0] kind;
   } kw_hit_type;

   function automatic kw_hit_type kw_lookup(input logic [63:0] name);
      kw_hit_type r;
      r.found = 1'b0;
      r.kind  = K_IDENT;
      for (int k = 0; k < 17; k++) begin
         if (!r.found && name == KW_NAME[k]) begin
            r.found = 1'b1;
            r.kind  = K_KW0 + 6'(k);
         end
      end
      return r;
   endfunction

endpackage

// ----- rtl/bts_ram.sv -----
// ----------------------------------------------------------------------------
// bts_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module bts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 63,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bts_queue.sv -----
// ----------------------------------------------------------------------------
// bts_queue
// Short command queue between the scanner front and the output back end.
// ----------------------------------------------------------------------------
module bts_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  bts_pkg::cmd_type push_cmd,
   output logic            full,
   input  logic            pop,
   output logic            head_valid,
   output bts_pkg::cmd_type head_cmd
);
   import bts_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;

   assign full       = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      fill_in   = fill_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/bts_front.sv -----
// ----------------------------------------------------------------------------
// bts_front
// Scanner front end: takes source bytes, tracks lexer state, queues tokens.
// ----------------------------------------------------------------------------
module bts_front #(
   parameter int STRING_CAP = bts_pkg::STRING_CAP_DEF,
   parameter int NAME_CAP   = bts_pkg::NAME_CAP_DEF,
   parameter int AW         = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_char_code,
   output logic             push,
   output bts_pkg::cmd_type push_cmd,
   input  logic             queue_full,
   input  logic             drain_done,
   output logic             ram_we,
   output logic [AW-1:0]    ram_waddr,
   output logic [7:0]       ram_wdata
);
   import bts_pkg::*;

   localparam logic [3:0] NAME_LIMIT = 4'(NAME_CAP - 2);
   localparam logic [5:0] STR_LIMIT  = 6'(STRING_CAP - 1);

   typedef enum logic [9:0] {
      M_IDLE    = 10'b00_0000_0001,
      M_COMMENT = 10'b00_0000_0010,
      M_INT     = 10'b00_0000_0100,
      M_DOT     = 10'b00_0000_1000,
      M_FRAC    = 10'b00_0001_0000,
      M_IDENT   = 10'b00_0010_0000,
      M_STRING  = 10'b00_0100_0000,
      M_LT      = 10'b00_1000_0000,
      M_GT      = 10'b01_0000_0000,
      M_BADDOT  = 10'b10_0000_0000
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [15:0] line_ff, line_in;
   logic [30:0] val_ff, val_in;
   logic [5:0]  frac_ff, frac_in;
   logic [63:0] name_ff, name_in;
   logic [3:0]  ncount_ff, ncount_in;
   logic [5:0]  scount_ff, scount_in;
   logic        halted_ff, halt_set;
   logic [7:0]  byte_ff;
   logic        busy_ff;
   logic        pend_ff;
   logic        finish, wr, stall, commit;

   logic        is_digit, is_alpha, is_sigil, rem_ok, is_rem_word;
   logic [3:0]  digit;
   logic [7:0]  up;
   logic [34:0] mul10;
   kw_hit_type  kw;

   assign req_ready = !busy_ff;

   always_comb begin
      is_digit = (byte_ff >= 8'h30) && (byte_ff <= 8'h39);
      is_alpha = ((byte_ff >= 8'h41) && (byte_ff <= 8'h5A)) ||
                 ((byte_ff >= 8'h61) && (byte_ff <= 8'h7A));
      is_sigil = (byte_ff == CH_DOLLAR) || (byte_ff == CH_PCT);
      digit    = byte_ff[3:0];
      up       = ((byte_ff >= 8'h61) && (byte_ff <= 8'h7A)) ? byte_ff - 8'd32 : byte_ff;
      mul10    = ({4'b0, val_ff} << 3) + ({4'b0, val_ff} << 1) + {31'b0, digit};
      kw       = kw_lookup(name_ff);
      // name so far is a proper prefix of REM and the new byte extends it
      rem_ok   = 1'b0;
      unique case (ncount_ff)
         4'd1:    rem_ok = (name_ff[7:0] == REM_NAME[7:0]) && (up == REM_NAME[15:8]);
         4'd2:    rem_ok = (name_ff[15:0] == REM_NAME[15:0]) && (up == REM_NAME[23:16]);
         default: rem_ok = 1'b0;
      endcase
      is_rem_word = (ncount_ff == 4'd3) && (name_ff[23:0] == REM_NAME);
   end

   always_comb begin
      mode_in   = mode_ff;
      line_in   = line_ff;
      val_in    = val_ff;
      frac_in   = frac_ff;
      name_in   = name_ff;
      ncount_in = ncount_ff;
      scount_in = scount_ff;
      push      = 1'b0;
      push_cmd  = '0;
      push_cmd.line = line_ff;
      finish    = 1'b0;
      halt_set  = 1'b0;
      wr        = 1'b0;
      if (busy_ff) begin
         unique case (mode_ff) inside
            M_IDLE: begin
               finish = 1'b1;
               case (byte_ff) inside
                  CH_SPACE, CH_TAB, CH_CR: ;
                  CH_NUL: begin
                     push = 1'b1;
                     push_cmd.kind = K_EOF;
                  end
                  CH_LF: begin
                     push = 1'b1;
                     push_cmd.kind = K_EOL;
                     if (line_ff != LINE_MAX) begin
                        line_in = line_ff + 16'd1;
                     end
                  end
                  CH_APOS:  mode_in = M_COMMENT;
                  CH_QUOTE: begin
                     mode_in   = M_STRING;
                     scount_in = '0;
                  end
                  CH_LT: mode_in = M_LT;
                  CH_GT: mode_in = M_GT;
                  CH_EQ:  begin push = 1'b1; push_cmd.kind = K_EQ;    end
                  8'h2B:  begin push = 1'b1; push_cmd.kind = K_PLUS;  end
                  8'h2D:  begin push = 1'b1; push_cmd.kind = K_MINUS; end
                  8'h2A:  begin push = 1'b1; push_cmd.kind = K_MUL;   end
                  8'h2F:  begin push = 1'b1; push_cmd.kind = K_DIV;   end
                  8'h28:  begin push = 1'b1; push_cmd.kind = K_LPAR;  end
                  8'h29:  begin push = 1'b1; push_cmd.kind = K_RPAR;  end
                  8'h2C:  begin push = 1'b1; push_cmd.kind = K_COMMA; end
                  8'h3B:  begin push = 1'b1; push_cmd.kind = K_SEMI;  end
                  8'h3A:  begin push = 1'b1; push_cmd.kind = K_COLON; end
                  default: begin
                     if (is_digit) begin
                        mode_in = M_INT;
                        val_in  = {27'b0, digit};
                        frac_in = '0;
                     end else if (is_alpha) begin
                        mode_in   = M_IDENT;
                        name_in   = {56'b0, up};
                        ncount_in = 4'd1;
                     end else begin
                        push = 1'b1;
                        push_cmd.kind = K_ERR;
                        push_cmd.err  = E_BAD_CHAR;
                        halt_set = 1'b1;
                     end
                  end
               endcase
            end
            M_COMMENT: begin
               if (byte_ff == CH_LF || byte_ff == CH_NUL) begin
                  mode_in = M_IDLE;
               end else begin
                  finish = 1'b1;
               end
            end
            M_INT: begin
               if (is_digit) begin
                  finish = 1'b1;
                  val_in = (mul10 > {4'b0, VAL_MAX}) ? VAL_MAX : mul10[30:0];
               end else if (byte_ff == CH_DOT) begin
                  finish  = 1'b1;
                  mode_in = M_DOT;
               end else begin
                  push = 1'b1;
                  push_cmd.kind  = K_INT;
                  push_cmd.value = val_ff;
                  mode_in = M_IDLE;
               end
            end
            M_DOT, M_FRAC: begin
               if (is_digit) begin
                  finish  = 1'b1;
                  mode_in = M_FRAC;
                  if (val_ff <= FRAC_LIM && frac_ff < 6'd63) begin
                     val_in  = mul10[30:0];
                     frac_in = frac_ff + 6'd1;
                  end
               end else begin
                  push = 1'b1;
                  push_cmd.value = val_ff;
                  if (mode_ff == M_DOT) begin
                     push_cmd.kind = K_INT;
                     mode_in = M_BADDOT;
                  end else begin
                     push_cmd.kind = K_REAL;
                     push_cmd.frac = frac_ff;
                     mode_in = M_IDLE;
                  end
               end
            end
            M_BADDOT: begin
               finish  = 1'b1;
               mode_in = M_IDLE;
               push    = 1'b1;
               push_cmd.kind = K_ERR;
               push_cmd.err  = E_BAD_CHAR;
               halt_set = 1'b1;
            end
            M_IDENT: begin
               if (is_digit || is_alpha) begin
                  finish = 1'b1;
                  if (ncount_ff >= NAME_LIMIT && !rem_ok) begin
                     push = 1'b1;
                     push_cmd.kind = K_ERR;
                     push_cmd.err  = E_NAME_LONG;
                     halt_set = 1'b1;
                  end else if (ncount_ff < 4'd8) begin
                     name_in   = name_ff | ({56'b0, up} << {ncount_ff[2:0], 3'b000});
                     ncount_in = ncount_ff + 4'd1;
                  end
               end else if (is_rem_word && !is_sigil) begin
                  mode_in = M_COMMENT;
               end else begin
                  mode_in = M_IDLE;
                  push    = 1'b1;
                  push_cmd.name = name_ff;
                  push_cmd.len  = ncount_ff;
                  if (kw.found) begin
                     push_cmd.kind = kw.kind;
                  end else begin
                     push_cmd.kind = K_IDENT;
                     if (is_sigil) begin
                        finish = 1'b1;
                        if (ncount_ff < 4'd8) begin
                           push_cmd.name = name_ff |
                              ({56'b0, byte_ff} << {ncount_ff[2:0], 3'b000});
                           push_cmd.len  = ncount_ff + 4'd1;
                        end
                     end
                  end
               end
            end
            M_STRING: begin
               finish = 1'b1;
               if (byte_ff == CH_QUOTE) begin
                  mode_in = M_IDLE;
                  push    = 1'b1;
                  push_cmd.kind  = K_STR;
                  push_cmd.drain = (scount_ff != '0);
                  push_cmd.count = scount_ff;
               end else if (byte_ff == CH_NUL || byte_ff == CH_LF) begin
                  push = 1'b1;
                  push_cmd.kind = K_ERR;
                  push_cmd.err  = E_UNTERM;
                  halt_set = 1'b1;
               end else if (scount_ff >= STR_LIMIT || scount_ff >= 6'd63) begin
                  push = 1'b1;
                  push_cmd.kind = K_ERR;
                  push_cmd.err  = E_STR_LONG;
                  halt_set = 1'b1;
               end else begin
                  wr        = 1'b1;
                  scount_in = scount_ff + 6'd1;
               end
            end
            M_LT, M_GT: begin
               mode_in = M_IDLE;
               push    = 1'b1;
               if (byte_ff == CH_EQ) begin
                  finish = 1'b1;
                  push_cmd.kind = (mode_ff == M_LT) ? K_LTE : K_GTE;
               end else if (mode_ff == M_LT && byte_ff == CH_GT) begin
                  finish = 1'b1;
                  push_cmd.kind = K_NEQ;
               end else begin
                  push_cmd.kind = (mode_ff == M_LT) ? K_LT : K_GT;
               end
            end
            default: mode_in = M_IDLE;
         endcase
      end
      stall  = (push && queue_full) || (wr && pend_ff);
      commit = busy_ff && !stall;
   end

   assign ram_we    = wr && commit;
   assign ram_waddr = scount_ff[AW-1:0];
   assign ram_wdata = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         line_ff   <= 16'd1;
         val_ff    <= '0;
         frac_ff   <= '0;
         name_ff   <= '0;
         ncount_ff <= '0;
         scount_ff <= '0;
         halted_ff <= 1'b0;
         busy_ff   <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            busy_ff <= !halted_ff;
         end
         if (commit) begin
            mode_ff   <= mode_in;
            line_ff   <= line_in;
            val_ff    <= val_in;
            frac_ff   <= frac_in;
            name_ff   <= name_in;
            ncount_ff <= ncount_in;
            scount_ff <= scount_in;
            if (halt_set) begin
               halted_ff <= 1'b1;
            end
            if (finish) begin
               busy_ff <= 1'b0;
            end
         end
         if (commit && push && push_cmd.drain) begin
            pend_ff <= 1'b1;
         end else if (drain_done) begin
            pend_ff <= 1'b0;
         end
      end
      if (req_valid && req_ready) begin
         byte_ff <= req_char_code;
      end
   end

endmodule

// ----- rtl/bts_back.sv -----
// ----------------------------------------------------------------------------
// bts_back
// Output back end: delivers queued tokens and drains buffered strings.
// ----------------------------------------------------------------------------
module bts_back #(
   parameter int AW = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  bts_pkg::cmd_type head_cmd,
   output logic             pop,
   output logic             drain_done,
   output logic [AW-1:0]    ram_raddr,
   input  logic [7:0]       ram_rdata,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [5:0]       rsp_kind,
   output logic [15:0]      rsp_line_number,
   output logic [30:0]      rsp_number_value,
   output logic [5:0]       rsp_frac_digits,
   output logic [63:0]      rsp_name_text,
   output logic [3:0]       rsp_name_length,
   output logic [7:0]       rsp_string_char,
   output logic             rsp_char_valid,
   output logic             rsp_last,
   output logic [2:0]       rsp_error_code
);
   import bts_pkg::*;

   typedef enum logic [1:0] {
      B_CMD   = 2'b01,
      B_DRAIN = 2'b10
   } back_state_type;

   back_state_type st_ff;
   logic [5:0]  idx_ff, cnt_ff;
   logic [15:0] dline_ff;
   logic        rd_ok_ff;
   logic        done_ff;
   logic        out_free;
   logic        load_char;

   logic        valid_ff, valid_in;
   logic [5:0]  kind_ff;
   logic [15:0] line_ff;
   logic [30:0] value_ff;
   logic [5:0]  frac_ff;
   logic [63:0] name_ff;
   logic [3:0]  len_ff;
   logic [7:0]  char_ff;
   logic        cvalid_ff;
   logic        last_ff;
   logic [2:0]  err_ff;

   assign out_free   = !valid_ff || rsp_ready;
   assign pop        = (st_ff == B_CMD) && head_valid && out_free;
   assign load_char  = (st_ff == B_DRAIN) && rd_ok_ff && out_free;
   assign ram_raddr  = idx_ff[AW-1:0];
   assign drain_done = done_ff;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      if ((pop && !head_cmd.drain) || load_char) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= B_CMD;
         valid_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
         done_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         done_ff  <= 1'b0;
         valid_ff <= valid_in;
         unique case (st_ff)
            B_CMD: begin
               if (pop && head_cmd.drain) begin
                  st_ff    <= B_DRAIN;
                  idx_ff   <= '0;
                  rd_ok_ff <= 1'b0;
               end
            end
            B_DRAIN: begin
               if (!rd_ok_ff) begin
                  rd_ok_ff <= 1'b1;
               end else if (out_free) begin
                  rd_ok_ff <= 1'b0;
                  if (idx_ff == cnt_ff - 6'd1) begin
                     st_ff   <= B_CMD;
                     done_ff <= 1'b1;
                  end else begin
                     idx_ff <= idx_ff + 6'd1;
                  end
               end
            end
            default: st_ff <= B_CMD;
         endcase
      end
      if (pop) begin
         cnt_ff   <= head_cmd.count;
         dline_ff <= head_cmd.line;
         kind_ff  <= head_cmd.kind;
         line_ff  <= head_cmd.line;
         value_ff <= head_cmd.value;
         frac_ff  <= head_cmd.frac;
         name_ff  <= head_cmd.name;
         len_ff   <= head_cmd.len;
         err_ff   <= head_cmd.err;
         char_ff  <= '0;
         cvalid_ff <= 1'b0;
         last_ff  <= 1'b1;
      end else if (load_char) begin
         kind_ff  <= K_STR;
         line_ff  <= dline_ff;
         value_ff <= '0;
         frac_ff  <= '0;
         name_ff  <= '0;
         len_ff   <= '0;
         err_ff   <= E_NONE;
         char_ff  <= ram_rdata;
         cvalid_ff <= 1'b1;
         last_ff  <= (idx_ff == cnt_ff - 6'd1);
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_line_number  = line_ff;
   assign rsp_number_value = value_ff;
   assign rsp_frac_digits  = frac_ff;
   assign rsp_name_text    = name_ff;
   assign rsp_name_length  = len_ff;
   assign rsp_string_char  = char_ff;
   assign rsp_char_valid   = cvalid_ff;
   assign rsp_last         = last_ff;
   assign rsp_error_code   = err_ff;

endmodule

// ----- rtl/basic_token_scanner.sv -----
// ----------------------------------------------------------------------------
// basic_token_scanner
// Streaming lexer for a small BASIC dialect, one source byte per transaction.
// Usage:
//   req_ carries one source byte per transaction, 0 marking end of text.
//   rsp_ carries tokens tagged with their line; a string literal comes out
//   as a run of character transactions, the final one with rsp_last set.
//   A byte is registered when taken and scanned in the next cycle, and no
//   new byte is taken until its scan is done; a byte that ends a token is
//   scanned again in the new mode, so after REM a line feed is scanned in
//   the name, comment and idle modes in turn. A token goes from the scan of
//   the byte that completes it through the token queue to the rsp_ outputs.
//   A string drains one character at a time through the registered string
//   buffer read port, each character waiting for its read to complete.
//   Characters of a following string wait until the drain is done.
//   A stalled receiver fills the four-entry token queue and then holds
//   req_ready low; no token is lost.
//   Reset returns the scanner to line one, idle. After an error token the
//   block drops all further bytes until reset.
// ----------------------------------------------------------------------------
module basic_token_scanner #(
   parameter int STRING_CAP = bts_pkg::STRING_CAP_DEF,
   parameter int NAME_CAP   = bts_pkg::NAME_CAP_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_kind,
   output logic [15:0] rsp_line_number,
   output logic [30:0] rsp_number_value,
   output logic [5:0]  rsp_frac_digits,
   output logic [63:0] rsp_name_text,
   output logic [3:0]  rsp_name_length,
   output logic [7:0]  rsp_string_char,
   output logic        rsp_char_valid,
   output logic        rsp_last,
   output logic [2:0]  rsp_error_code
);
   import bts_pkg::*;

   localparam int STR_DEPTH = STRING_CAP - 1;
   localparam int AW        = (STR_DEPTH > 1) ? $clog2(STR_DEPTH) : 1;

   cmd_type          push_cmd, head_cmd;
   logic             push, pop, queue_full, head_valid, drain_done;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic [7:0]       ram_wdata, ram_rdata;

   bts_front #(
      .STRING_CAP(STRING_CAP),
      .NAME_CAP(NAME_CAP),
      .AW(AW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_char_code(req_char_code),
      .push(push),
      .push_cmd(push_cmd),
      .queue_full(queue_full),
      .drain_done(drain_done),
      .ram_we(ram_we),
      .ram_waddr(ram_waddr),
      .ram_wdata(ram_wdata)
   );

   bts_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push && !queue_full),
      .push_cmd(push_cmd),
      .full(queue_full),
      .pop(pop),
      .head_valid(head_valid),
      .head_cmd(head_cmd)
   );

   bts_ram #(
      .WIDTH(8),
      .DEPTH(STR_DEPTH),
      .AW(AW)
   ) u_str_ram (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   bts_back #(
      .AW(AW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_cmd(head_cmd),
      .pop(pop),
      .drain_done(drain_done),
      .ram_raddr(ram_raddr),
      .ram_rdata(ram_rdata),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_line_number(rsp_line_number),
      .rsp_number_value(rsp_number_value),
      .rsp_frac_digits(rsp_frac_digits),
      .rsp_name_text(rsp_name_text),
      .rsp_name_length(rsp_name_length),
      .rsp_string_char(rsp_string_char),
      .rsp_char_valid(rsp_char_valid),
      .rsp_last(rsp_last),
      .rsp_error_code(rsp_error_code)
   );

endmodule
